@@ design/mixture_log_likelihood_accumulator_unit_assert.svh @@
// Assertion macros for the port-level checker.
// No dependencies.
`ifndef MIXTURE_LOG_LIKELIHOOD_ACCUMULATOR_UNIT_ASSERT_SVH
`define MIXTURE_LOG_LIKELIHOOD_ACCUMULATOR_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define MLA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define MLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ design/mla_pkg.sv @@
// Package for the mixture log-likelihood accumulator: widths and constants.
// No dependencies.
package mla_pkg;
   localparam int LANES     = 4;
   localparam int LIK_W     = 16;
   localparam int PROD_W    = 32;
   localparam int P_W       = 34;
   localparam int ACC_W     = 56;
   localparam int LOG_W     = 37;   // |L| Q.30 plus sign room
   localparam int LOG_ITERS = 30;
   localparam logic [27:0] LN2_Q28 = 28'hB17217F;

   typedef enum logic [1:0] {
      CSR_WEIGHT_A = 2'd0,
      CSR_WEIGHT_C = 2'd1,
      CSR_WEIGHT_G = 2'd2,
      CSR_WEIGHT_T = 2'd3
   } csr_index_type;
endpackage

@@ design/mla_if.sv @@
// Valid/ready channel interfaces for the accumulator.
// No dependencies.
interface mla_req_if (input logic clock);
   logic valid;
   logic ready;
   logic [15:0] lik_a;
   logic [15:0] lik_c;
   logic [15:0] lik_g;
   logic [15:0] lik_t;
   logic [15:0] obs_count;
   logic last_item;
   modport source (output valid, lik_a, lik_c, lik_g, lik_t, obs_count, last_item,
                   input ready);
   modport sink (input valid, lik_a, lik_c, lik_g, lik_t, obs_count, last_item,
                 output ready);
endinterface

interface mla_rsp_if (input logic clock);
   logic valid;
   logic ready;
   logic [55:0] log_sum;
   logic zero_prob;
   logic invalid_weights;
   modport source (output valid, log_sum, zero_prob, invalid_weights, input ready);
   modport sink (input valid, log_sum, zero_prob, invalid_weights, output ready);
endinterface

interface mla_csr_if (input logic clock);
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/mla_lane.sv @@
// One lane: weight times likelihood, registered.
// Depends on mla_pkg.
module mla_lane (
   input  logic                       clock,
   input  logic                       load,
   input  logic [mla_pkg::LIK_W-1:0]  weight,
   input  logic [mla_pkg::LIK_W-1:0]  lik,
   output logic [mla_pkg::PROD_W-1:0] prod
);
   logic [mla_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= weight * lik;
      end
   end
   assign prod = prod_ff;
endmodule

@@ design/mla_log.sv @@
// Iterative log2 by repeated squaring, then scale by ln 2 and round.
// Depends on mla_pkg.
module mla_log #(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [mla_pkg::P_W-1:0]  p,
   output logic                     done,
   output logic signed [mla_pkg::ACC_W-1:0] ln_out
);
   localparam int SHIFT = 58 - FRAC_BITS;
   localparam logic [1:0] ST_IDLE = 2'd0, ST_SQ = 2'd1, ST_MUL = 2'd2, ST_OUT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        done_ff;
   logic [4:0]  iter_ff, iter_in;
   logic [32:0] m_ff, m_in;
   logic [29:0] frac_ff, frac_in;
   logic signed [6:0] e_ff, e_in;
   logic [mla_pkg::LOG_W-1:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [64:0] prod_ff, prod_in;
   logic signed [mla_pkg::ACC_W-1:0] res_ff, res_in;
   logic [5:0]  top;
   logic [65:0] sq;
   logic [33:0] msq;
   logic signed [mla_pkg::LOG_W:0] l;
   logic [64:0] rnd;

   always_comb begin
      top = 6'd0;
      for (int i = 0; i < mla_pkg::P_W; i++) begin
         if (p[i]) top = 6'(i);
      end
   end

   assign sq  = m_ff * m_ff;
   assign msq = sq[64:31];
   assign l = (mla_pkg::LOG_W+1)'(signed'(e_ff - 7'sd32)) * 38'sd1073741824
              + (mla_pkg::LOG_W+1)'(frac_ff);
   assign rnd = prod_ff + (65'd1 << (SHIFT - 1));

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      e_in     = e_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               e_in = 7'(top);
               m_in = (top <= 6'd31) ? 33'(p << (6'd31 - top)) : 33'(p >> (top - 6'd31));
               frac_in = '0;
               iter_in = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (msq[33:32] != 2'b00) begin
               frac_in = {frac_ff[28:0], 1'b1};
               m_in = msq[33:1];
            end else begin
               frac_in = {frac_ff[28:0], 1'b0};
               m_in = msq[32:0];
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(mla_pkg::LOG_ITERS - 1)) state_in = ST_MUL;
         end
         ST_MUL: begin
            neg_in = l[mla_pkg::LOG_W];
            mag_in = l[mla_pkg::LOG_W] ? mla_pkg::LOG_W'(-l) : mla_pkg::LOG_W'(l);
            state_in = ST_OUT;
            prod_in = '0;
         end
         ST_OUT: begin
            if (prod_ff == '0 && mag_ff != '0) begin
               prod_in = 65'(mag_ff) * 65'(mla_pkg::LN2_Q28);
            end else begin
               res_in = neg_ff ? -mla_pkg::ACC_W'(rnd >> SHIFT)
                               : mla_pkg::ACC_W'(rnd >> SHIFT);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == ST_OUT) && (state_in == ST_IDLE);
      end
      iter_ff <= iter_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      e_ff    <= e_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign ln_out = res_ff;
endmodule

@@ design/mixture_log_likelihood_accumulator_unit.sv @@
// Top level of the mixture log-likelihood accumulator.
// Depends on mla_pkg, mla_if, mla_lane and mla_log.
//
// Usage:
//  - csr channel writes the four Q0.16 weights (index 0..3 = A, C, G, T);
//    always ready, write only while idle.
//  - req channel: one beat per observation: four likelihoods, a count and
//    a last flag. Items with zero count add nothing.
//  - rsp channel: one beat on each last item with the saturated 56-bit sum,
//    the zero-probability flag and the weight-invalid flag.
// Throughput: one item at a time. A counted item holds req ready low
// while the 30 squaring steps of the shared log unit run; zero-probability
// and skipped items do not start the log unit.
// The rsp beat is registered in S_OUT, after the sum is updated.
// Four lanes form the weighted products in parallel, a merge adds them.
// Reset restores the weights to 16384 each and clears the sum and flag.
// A stalled rsp holds its beat; req ready stays low until it is taken.
module mixture_log_likelihood_accumulator_unit #(
   parameter int FRAC_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input logic clock,
   input logic reset,
   mla_req_if.sink   req,
   mla_rsp_if.source rsp,
   mla_csr_if.sink   csr
);
   localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_SUM = 3'd2,
                          S_LOG = 3'd3, S_TERM = 3'd4, S_ACC = 3'd5, S_OUT = 3'd6;
   localparam logic signed [mla_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(mla_pkg::ACC_W-1){1'b1}}};
   localparam logic signed [mla_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(mla_pkg::ACC_W-1){1'b0}}};

   logic [15:0] w_ff [4];
   logic [2:0]  state_ff;
   logic [mla_pkg::LIK_W-1:0] lik_ff [4];
   logic [COUNT_BITS-1:0] cnt_ff;
   logic last_ff;
   logic [mla_pkg::PROD_W-1:0] prod [4];
   logic [mla_pkg::P_W-1:0] p_ff;
   logic signed [mla_pkg::ACC_W-1:0] acc_ff;
   logic zero_ff;
   logic signed [mla_pkg::ACC_W+COUNT_BITS:0] term_ff;
   logic signed [mla_pkg::ACC_W+COUNT_BITS+1:0] sum;
   logic log_done;
   logic signed [mla_pkg::ACC_W-1:0] ln_val;
   logic rsp_valid_ff;
   logic [55:0] rsp_sum_ff;
   logic rsp_zero_ff, rsp_inv_ff;
   logic [17:0] wsum;

   assign csr.ready = 1'b1;
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   for (genvar g = 0; g < mla_pkg::LANES; g++) begin : g_lane
      mla_lane u_lane (.clock(clock), .load(state_ff == S_MUL), .weight(w_ff[g]),
                       .lik(lik_ff[g]), .prod(prod[g]));
   end

   // log unit only runs when its result is awaited
   mla_log #(.FRAC_BITS(FRAC_BITS)) u_log (
      .clock(clock), .reset(reset),
      .start(state_ff == S_LOG && p_ff != '0 && !zero_ff),
      .p(p_ff), .done(log_done), .ln_out(ln_val));

   assign sum = (mla_pkg::ACC_W+COUNT_BITS+2)'(acc_ff)
              + (mla_pkg::ACC_W+COUNT_BITS+2)'(term_ff);
   assign wsum = 18'(w_ff[0]) + 18'(w_ff[1]) + 18'(w_ff[2]) + 18'(w_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < 4; i++) w_ff[i] <= 16'd16384;
         acc_ff <= '0;
         zero_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) w_ff[csr.index] <= csr.data;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               lik_ff[0] <= req.lik_a;
               lik_ff[1] <= req.lik_c;
               lik_ff[2] <= req.lik_g;
               lik_ff[3] <= req.lik_t;
               cnt_ff <= COUNT_BITS'(req.obs_count);
               last_ff <= req.last_item;
               state_ff <= (COUNT_BITS'(req.obs_count) == '0) ? S_OUT : S_MUL;
            end
            S_MUL: state_ff <= S_SUM;
            S_SUM: begin
               // merge stage: add the four lane products
               p_ff <= mla_pkg::P_W'(prod[0]) + mla_pkg::P_W'(prod[1])
                     + mla_pkg::P_W'(prod[2]) + mla_pkg::P_W'(prod[3]);
               state_ff <= S_LOG;
            end
            S_LOG: begin
               if (p_ff == '0) begin
                  zero_ff <= 1'b1;
                  acc_ff <= ACC_MIN;
                  state_ff <= S_OUT;
               end else if (zero_ff) begin
                  acc_ff <= ACC_MIN;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_TERM;
               end
            end
            S_TERM: if (log_done) begin
               term_ff <= $signed(ln_val) * $signed({1'b0, cnt_ff});
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (sum > (mla_pkg::ACC_W+COUNT_BITS+2)'(ACC_MAX)) acc_ff <= ACC_MAX;
               else if (sum < (mla_pkg::ACC_W+COUNT_BITS+2)'(ACC_MIN)) acc_ff <= ACC_MIN;
               else acc_ff <= mla_pkg::ACC_W'(sum);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (last_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_sum_ff <= acc_ff;
                  rsp_zero_ff <= zero_ff;
                  rsp_inv_ff <= (w_ff[0] == 0) || (w_ff[1] == 0) || (w_ff[2] == 0)
                                || (w_ff[3] == 0) || (wsum != 18'd65536);
                  acc_ff <= '0;
                  zero_ff <= 1'b0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.log_sum = rsp_sum_ff;
   assign rsp.zero_prob = rsp_zero_ff;
   assign rsp.invalid_weights = rsp_inv_ff;
endmodule

@@ design/mla_checker.sv @@
// Port-level checker for the accumulator, bound to the top level.
// Depends on the assertion macro header.
`include "mixture_log_likelihood_accumulator_unit_assert.svh"
module mla_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_zero_prob,
   input logic [55:0] rsp_log_sum
);
   `MLA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MLA_ASSERT_IMP(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   `MLA_ASSERT_IMP(a_zero_pins, clock, reset, rsp_valid && rsp_zero_prob,
      rsp_log_sum == 56'h80000000000000)
endmodule

bind mixture_log_likelihood_accumulator_unit mla_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_zero_prob(rsp.zero_prob),
   .rsp_log_sum(rsp.log_sum));

@@ tb/sv/testbench.sv @@
// Self-checking testbench for mixture_log_likelihood_accumulator_unit.
// Depends on mla_pkg, the mla_*_if interfaces and the unit itself; drives
// random bursts, predicts each locus sum and compares every rsp beat.
`timescale 1ns / 100ps

module testbench;

   localparam int FRAC       = 16;
   localparam int CNT_BITS   = 16;
   localparam int CYCLE_CAP  = 600000;
   localparam int DRAIN_WAIT = 60;

   typedef struct packed {
      logic [mla_pkg::ACC_W-1:0] log_sum;
      logic                      zero_prob;
      logic                      invalid_weights;
   } locus_result_type;

   // Holds weights, running sum and the queue of locus results still due.
   class locus_scoreboard;
      logic [15:0] weight [4];
      longint acc;
      bit zero_seen;
      locus_result_type due_q [$];
      int errors;

      function void reset_state();
         for (int i = 0; i < 4; i++) weight[i] = 16'd16384;
         acc = 0;
         zero_seen = 0;
         due_q.delete();
         errors = 0;
      endfunction

      // round(ln(p / 2^32) * 2^FRAC) via squaring log2, then * ln2
      function longint ln_fixed(longint unsigned p);
         int e;
         longint unsigned m, frac, mag, prod;
         longint l;
         e = 33;
         frac = 0;
         while (e > 0 && p[e] == 1'b0) e--;
         m = (e <= 31) ? (p << (31 - e)) : (p >> (e - 31));
         for (int i = 0; i < mla_pkg::LOG_ITERS; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
               frac = frac | 64'd1;
               m = m >> 1;
            end
         end
         l = longint'(e - 32) * 64'sh4000_0000 + longint'(frac);
         mag = (l < 0) ? longint'(-l) : l;
         prod = mag * 64'h0B17217F;
         prod = (prod + (64'd1 << (57 - FRAC))) >> (58 - FRAC);
         return (l < 0) ? -longint'(prod) : longint'(prod);
      endfunction

      function void note_item(logic [15:0] la, logic [15:0] lc, logic [15:0] lg,
                              logic [15:0] lt, logic [15:0] cnt, logic last);
         longint unsigned p;
         longint unsigned count;
         longint r;
         locus_result_type res;
         bit bad;
         count = cnt & ((64'd1 << CNT_BITS) - 1);
         if (count != 0) begin
            p = weight[0] * la + weight[1] * lc + weight[2] * lg + weight[3] * lt;
            if (p == 0) zero_seen = 1;
            if (zero_seen) begin
               acc = -(64'sd1 <<< 55);
            end else begin
               r = acc + ln_fixed(p) * longint'(count);
               if (r > (64'sd1 <<< 55) - 1) r = (64'sd1 <<< 55) - 1;
               if (r < -(64'sd1 <<< 55)) r = -(64'sd1 <<< 55);
               acc = r;
            end
         end
         if (!last) return;
         bad = weight[0] == 0 || weight[1] == 0 || weight[2] == 0 || weight[3] == 0 ||
               (32'(weight[0]) + weight[1] + weight[2] + weight[3]) != 32'd65536;
         res.log_sum = acc[mla_pkg::ACC_W-1:0];
         res.zero_prob = zero_seen;
         res.invalid_weights = bad;
         due_q.push_back(res);
         acc = 0;
         zero_seen = 0;
      endfunction

      function void check_result(locus_result_type got);
         locus_result_type want;
         if (due_q.size() == 0) begin
            $display("%0t: unexpected rsp beat sum=%h zero=%b inv=%b", $time,
                     got.log_sum, got.zero_prob, got.invalid_weights);
            errors++;
            return;
         end
         want = due_q.pop_front();
         if (got.log_sum !== want.log_sum) begin
            $display("%0t: log_sum expected %h actual %h", $time, want.log_sum, got.log_sum);
            errors++;
         end
         if (got.zero_prob !== want.zero_prob) begin
            $display("%0t: zero_prob expected %b actual %b", $time,
                     want.zero_prob, got.zero_prob);
            errors++;
         end
         if (got.invalid_weights !== want.invalid_weights) begin
            $display("%0t: invalid_weights expected %b actual %b", $time,
                     want.invalid_weights, got.invalid_weights);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #10 clock = ~clock;

   mla_req_if req_if (clock);
   mla_rsp_if rsp_if (clock);
   mla_csr_if csr_if (clock);

   mixture_log_likelihood_accumulator_unit #(.FRAC_BITS(FRAC), .COUNT_BITS(CNT_BITS)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source),
      .csr   (csr_if.sink)
   );

   locus_scoreboard sb;
   int cycles = 0;
   int burst_left = 0;

   initial begin
      sb = new();
      sb.reset_state();
      req_if.valid = 1'b0;
      req_if.lik_a = '0;
      req_if.lik_c = '0;
      req_if.lik_g = '0;
      req_if.lik_t = '0;
      req_if.obs_count = '0;
      req_if.last_item = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = mla_pkg::CSR_WEIGHT_A;
      csr_if.data = '0;
   end

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_item(req_if.lik_a, req_if.lik_c, req_if.lik_g, req_if.lik_t,
                         req_if.obs_count, req_if.last_item);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result({rsp_if.log_sum, rsp_if.zero_prob, rsp_if.invalid_weights});
      end
   end

   // cycle cap
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("mixture_log_likelihood_accumulator_unit: mismatch");
         $finish;
      end
   end

   // rsp stall pattern: stretches of always-ready, coin flips, mostly-ready and long stalls
   int stall_mode = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(5, 80);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_if.ready = 1'b1;
         1: rsp_if.ready = $urandom_range(0, 1);
         2: rsp_if.ready = ($urandom_range(0, 19) == 0);
         default: rsp_if.ready = ($urandom_range(0, 3) != 0);
      endcase
   end

   // one req beat; valid stays high into the next beat unless a gap follows
   task automatic send_item(logic [15:0] la, logic [15:0] lc, logic [15:0] lg,
                            logic [15:0] lt, logic [15:0] cnt, logic last);
      int gap;
      req_if.lik_a = la;
      req_if.lik_c = lc;
      req_if.lik_g = lg;
      req_if.lik_t = lt;
      req_if.obs_count = cnt;
      req_if.last_item = last;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic write_weight(mla_pkg::csr_index_type idx, logic [15:0] value);
      csr_if.index = idx;
      csr_if.data = value;
      csr_if.valid = 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      sb.weight[idx] = value;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // wait for every locus to come back, then let the log unit drain
   task automatic wait_idle();
      req_if.valid = 1'b0;
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_weights(logic [15:0] a, logic [15:0] c, logic [15:0] g,
                              logic [15:0] t);
      wait_idle();
      write_weight(mla_pkg::CSR_WEIGHT_A, a);
      write_weight(mla_pkg::CSR_WEIGHT_C, c);
      write_weight(mla_pkg::CSR_WEIGHT_G, g);
      write_weight(mla_pkg::CSR_WEIGHT_T, t);
   endtask

   function automatic logic [15:0] rand_lik();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_count();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 20));
      endcase
   endfunction

   // random loci, each closed by a last beat; mostly well formed likelihoods
   task automatic random_loci(int n_items);
      int sent;
      int len;
      logic [15:0] la;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            la = rand_lik();
            // an all-zero row is rare so most loci reach a real sum
            if ($urandom_range(0, 9) != 0 && la == 0) la = 16'd1;
            send_item(la, rand_lik(), rand_lik(), rand_lik(), rand_count(), i == len - 1);
         end
         sent += len;
      end
   endtask

   logic [15:0] wa, wc, wg;

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset weights
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
      send_item(16'd0, 16'd0, 16'd0, 16'd0, 16'd3, 1'b1);          // zero probability
      send_item(16'h1234, 16'h0F0F, 16'hA5A5, 16'h5A5A, 16'd0, 1'b1); // skipped last
      send_item(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF, 1'b1);       // tiny p, max count
      send_item(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0);
      send_item(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd2, 1'b0);
      send_item(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0);
      send_item(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd5, 1'b1);
      send_item(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0);          // zero then more items
      send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd7, 1'b1);

      // weights above one: p beyond 2^32 gives positive terms
      set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

      // zero weight: only base A lit gives p of zero
      set_weights(16'd0, 16'd32768, 16'd16384, 16'd16384);
      send_item(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd4, 1'b1);
      send_item(16'd100, 16'd200, 16'd300, 16'd400, 16'd9, 1'b1);

      // smallest legal weights on three bases
      set_weights(16'd1, 16'd1, 16'd1, 16'd65533);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 1'b1);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b1);

      // random phases over several weight settings
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_weights(16'd16384, 16'd16384, 16'd16384, 16'd16384);
            1: set_weights(16'd65533, 16'd1, 16'd1, 16'd1);
            2: set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: set_weights(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            default: begin
               wa = 16'($urandom_range(1, 65533));
               wc = 16'($urandom_range(1, 65534 - wa));
               wg = 16'($urandom_range(1, 65535 - wa - wc));
               set_weights(wa, wc, wg, 16'(65536 - wa - wc - wg));
            end
         endcase
         random_loci(62);
      end

      wait_idle();
      if (sb.errors == 0 && sb.due_q.size() == 0) begin
         $display("mixture_log_likelihood_accumulator_unit: match");
      end else begin
         $display("mixture_log_likelihood_accumulator_unit: mismatch");
      end
      $finish;
   end
endmodule
